### sv/assert_macros.svh
// Assertion macros shared by the classifier RTL.
// Needs nothing else; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RPCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RPCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rpcc_pkg.sv
// Types, codes and sizes of the region priority cell classifier.
// Used by the classifier RTL and the testbench; depends on nothing.
package rpcc_pkg;

  localparam int MAX_REGIONS    = 16;
  localparam int COORD_W        = 32;
  localparam int RADIUS_W       = 31;
  localparam int RCOUNT_W       = 5;
  localparam int REGION_INDEX_W = 5;
  localparam int SLOT_W         = 4;
  localparam int SHAPE_W        = 2;
  localparam int IDX_W          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W          = $clog2(MAX_REGIONS + 1);
  localparam int MUL_W          = RADIUS_W;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int SUM_W          = PROD_W + 1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CELL = 1'b1;

  localparam logic [SHAPE_W-1:0] SHAPE_RECT   = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_POINT  = 2'd2;

  typedef struct packed {
    logic [SHAPE_W-1:0]         shape;
    logic signed [COORD_W-1:0]  x_min;
    logic signed [COORD_W-1:0]  x_max;
    logic signed [COORD_W-1:0]  y_min;
    logic signed [COORD_W-1:0]  y_max;
    logic [RADIUS_W-1:0]        radius;
  } rpcc_entry_t;

  localparam int ENTRY_W = $bits(rpcc_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_SQ_DX,
    ST_SQ_DY,
    ST_SQ_R,
    ST_CMP,
    ST_DONE
  } rpcc_state_e;

endpackage

### sv/rpcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module rpcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/region_priority_cell_classifier.sv
// Region priority cell classifier: region table in rpcc_ram, sequencer and
// one shared squaring multiplier. Depends on rpcc_pkg and assert_macros.svh.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one transaction
// per item. kind_i = 0 loads table entry slot_i (region slot_i+1); the
// block stays ready and gives no result. kind_i = 1 classifies a cell
// against regions 1..region_count in order, last match wins, and
// returns one region_index_o transaction on the output channel
// (out_valid_o/out_ready_i), 0 meaning background. Classification
// walks the table one entry at a time through a single read port: a
// rectangle, point or unused-shape entry is decided in the evaluate
// step, a circle ends early when the distance box already rules it
// out, else after three squarings on the one multiplier, then the
// compare. in_ready_o stays low while a cell is in progress.
// region_count_we_i writes region_count_i at once; write it only while idle.
// Reset clears region_count and the control state; table entries hold
// garbage until loaded. A stalled receiver holds the result in the output
// register; a following cell then waits at its end until that drains.
module region_priority_cell_classifier (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    region_count_we_i,
  input  logic [rpcc_pkg::RCOUNT_W-1:0]           region_count_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    kind_i,
  input  logic [rpcc_pkg::SLOT_W-1:0]             slot_i,
  input  logic [rpcc_pkg::SHAPE_W-1:0]            shape_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     x_low_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     x_high_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     y_low_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     y_high_i,
  input  logic [rpcc_pkg::RADIUS_W-1:0]           radius_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     center_x_i,
  input  logic signed [rpcc_pkg::COORD_W-1:0]     center_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [rpcc_pkg::REGION_INDEX_W-1:0]     region_index_o
);

`include "assert_macros.svh"

  rpcc_pkg::rpcc_state_e state_q, state_d;

  logic [rpcc_pkg::RCOUNT_W-1:0]       region_count_q;
  logic [rpcc_pkg::CNT_W-1:0]          idx_q, idx_d;
  logic [rpcc_pkg::CNT_W-1:0]          count_q, count_d;
  logic [rpcc_pkg::CNT_W-1:0]          win_q, win_d;
  logic [rpcc_pkg::CNT_W-1:0]          idx_next;
  logic [rpcc_pkg::CNT_W-1:0]          count_sel;
  logic                                out_valid_q, out_valid_d;
  logic [rpcc_pkg::REGION_INDEX_W-1:0] out_index_q, out_index_d;

  logic signed [rpcc_pkg::COORD_W-1:0] xl_q, xh_q, yl_q, yh_q, cx_q, cy_q;
  logic [rpcc_pkg::COORD_W-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic [rpcc_pkg::PROD_W-1:0]         prod_q, prod_d;
  logic [rpcc_pkg::SUM_W-1:0]          sum_q, sum_d;
  logic [rpcc_pkg::MUL_W-1:0]          mul_op;

  logic [rpcc_pkg::COORD_W:0]          diff_x, diff_y;

  logic                                accept;
  logic                                decide, hit;
  logic                                ram_we, ram_re;
  logic [rpcc_pkg::IDX_W-1:0]          ram_raddr;
  rpcc_pkg::rpcc_entry_t               wr_entry, ent;
  logic [rpcc_pkg::ENTRY_W-1:0]        ram_rdata;

  assign accept = in_valid_i && in_ready_o;

  assign wr_entry.shape  = shape_i;
  assign wr_entry.x_min  = x_low_i;
  assign wr_entry.x_max  = x_high_i;
  assign wr_entry.y_min  = y_low_i;
  assign wr_entry.y_max  = y_high_i;
  assign wr_entry.radius = radius_i;

  assign ram_we = accept && (kind_i == rpcc_pkg::KIND_LOAD) &&
                  (32'(slot_i) < 32'(rpcc_pkg::MAX_REGIONS));

  rpcc_ram #(
    .WIDTH (rpcc_pkg::ENTRY_W),
    .DEPTH (rpcc_pkg::MAX_REGIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rpcc_pkg::IDX_W'(slot_i)),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent = rpcc_pkg::rpcc_entry_t'(ram_rdata);

  // Counts above the table size clamp to the table size.
  assign count_sel = (32'(region_count_q) > 32'(rpcc_pkg::MAX_REGIONS)) ?
                     rpcc_pkg::CNT_W'(rpcc_pkg::MAX_REGIONS) :
                     rpcc_pkg::CNT_W'(region_count_q);

  assign idx_next = idx_q + rpcc_pkg::CNT_W'(1);

  // Signed differences, one bit wider so they never wrap.
  assign diff_x = {cx_q[rpcc_pkg::COORD_W-1], cx_q} - {ent.x_min[rpcc_pkg::COORD_W-1], ent.x_min};
  assign diff_y = {cy_q[rpcc_pkg::COORD_W-1], cy_q} - {ent.y_min[rpcc_pkg::COORD_W-1], ent.y_min};

  // Shared squaring unit: dx, then dy, then the radius.
  always_comb begin
    mul_op = dx_q[rpcc_pkg::MUL_W-1:0];
    case (state_q)
      rpcc_pkg::ST_SQ_DY: mul_op = dy_q[rpcc_pkg::MUL_W-1:0];
      rpcc_pkg::ST_SQ_R:  mul_op = ent.radius;
      default:            mul_op = dx_q[rpcc_pkg::MUL_W-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    win_d       = win_q;
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    in_ready_o  = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    decide      = 1'b0;
    hit         = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rpcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && (kind_i == rpcc_pkg::KIND_CELL)) begin
          idx_d   = '0;
          win_d   = '0;
          count_d = count_sel;
          if (count_sel == '0) begin
            state_d = rpcc_pkg::ST_DONE;
          end else begin
            ram_re  = 1'b1;
            state_d = rpcc_pkg::ST_EVAL;
          end
        end
      end
      rpcc_pkg::ST_EVAL: begin
        case (ent.shape)
          rpcc_pkg::SHAPE_RECT: begin
            decide = 1'b1;
            hit    = (xh_q >= ent.x_min) && (xl_q < ent.x_max) &&
                     (yh_q >= ent.y_min) && (yl_q < ent.y_max);
          end
          rpcc_pkg::SHAPE_CIRCLE: begin
            dx_d    = diff_x[rpcc_pkg::COORD_W] ? rpcc_pkg::COORD_W'(-diff_x) :
                                                  diff_x[rpcc_pkg::COORD_W-1:0];
            dy_d    = diff_y[rpcc_pkg::COORD_W] ? rpcc_pkg::COORD_W'(-diff_y) :
                                                  diff_y[rpcc_pkg::COORD_W-1:0];
            state_d = rpcc_pkg::ST_CHECK;
          end
          rpcc_pkg::SHAPE_POINT: begin
            decide = 1'b1;
            hit    = (xl_q == ent.x_min) && (yl_q == ent.y_min);
          end
          default: begin
            decide = 1'b1;
          end
        endcase
      end
      rpcc_pkg::ST_CHECK: begin
        // Drop early when either offset alone exceeds the radius.
        if ((dx_q > {1'b0, ent.radius}) || (dy_q > {1'b0, ent.radius})) begin
          decide = 1'b1;
        end else begin
          state_d = rpcc_pkg::ST_SQ_DX;
        end
      end
      rpcc_pkg::ST_SQ_DX: begin
        prod_d  = mul_op * mul_op;
        state_d = rpcc_pkg::ST_SQ_DY;
      end
      rpcc_pkg::ST_SQ_DY: begin
        prod_d  = mul_op * mul_op;
        sum_d   = rpcc_pkg::SUM_W'(prod_q);
        state_d = rpcc_pkg::ST_SQ_R;
      end
      rpcc_pkg::ST_SQ_R: begin
        prod_d  = mul_op * mul_op;
        sum_d   = sum_q + rpcc_pkg::SUM_W'(prod_q);
        state_d = rpcc_pkg::ST_CMP;
      end
      rpcc_pkg::ST_CMP: begin
        decide = 1'b1;
        hit    = (sum_q <= rpcc_pkg::SUM_W'(prod_q));
      end
      rpcc_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_index_d = rpcc_pkg::REGION_INDEX_W'(win_q);
          state_d     = rpcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpcc_pkg::ST_IDLE;
      end
    endcase

    // Record the match and advance to the next entry or finish.
    if (decide) begin
      if (hit) begin
        win_d = idx_next;
      end
      if (idx_next == count_q) begin
        state_d = rpcc_pkg::ST_DONE;
      end else begin
        idx_d     = idx_next;
        ram_re    = 1'b1;
        ram_raddr = rpcc_pkg::IDX_W'(idx_next);
        state_d   = rpcc_pkg::ST_EVAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
      idx_q          <= '0;
      count_q        <= '0;
      win_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (region_count_we_i) begin
        region_count_q <= region_count_i;
      end
      idx_q       <= idx_d;
      count_q     <= count_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == rpcc_pkg::KIND_CELL)) begin
      xl_q <= x_low_i;
      xh_q <= x_high_i;
      yl_q <= y_low_i;
      yh_q <= y_high_i;
      cx_q <= center_x_i;
      cy_q <= center_y_i;
    end
    out_index_q <= out_index_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    prod_q      <= prod_d;
    sum_q       <= sum_d;
  end

  assign out_valid_o    = out_valid_q;
  assign region_index_o = out_index_q;

  `RPCC_ASSERT(a_idx_in_range, clk_i, rst_ni, (state_q != rpcc_pkg::ST_IDLE && state_q != rpcc_pkg::ST_DONE) |-> (idx_q < count_q), "walk index beyond region count")
  `RPCC_ASSERT_ALWAYS(a_win_bounded, clk_i, !rst_ni || (win_q <= count_q), "winning region beyond region count")
  `RPCC_ASSERT(a_cell_blocks, clk_i, rst_ni, (accept && kind_i == rpcc_pkg::KIND_CELL) |=> !in_ready_o, "ready while a cell is in progress")
  `RPCC_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o) |-> ($past(state_q) == rpcc_pkg::ST_DONE), "result issued outside the done step")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for region_priority_cell_classifier.
// Drives region loads and cell lookups and checks every region index against
// a predictor or a fixed expected value. Depends on rpcc_pkg and the classifier RTL only.
module tb;
  import rpcc_pkg::*;

  localparam logic [SHAPE_W-1:0]        SHAPE_NONE  = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MIN       = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_NEG_ONE   = 32'shFFFF_FFFF;
  localparam logic [RADIUS_W-1:0]       R_MAX       = '1;
  localparam int                        IDLE_SETTLE = 8;
  localparam int                        END_SETTLE  = 120;
  localparam int                        HOLD_AT     = 1000;
  localparam int                        HOLD_LEN    = 400;
  localparam int                        CHUNKS      = 19;
  localparam int                        CHUNK_ITEMS = 100;

  typedef struct packed {
    logic                      kind;
    logic [SLOT_W-1:0]         slot;
    logic [SHAPE_W-1:0]        shape;
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
    logic [RADIUS_W-1:0]       radius;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
  } region_req_t;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_op_e;

  typedef struct {
    row_op_e                   op;
    region_req_t               req;
    logic [RCOUNT_W-1:0]       count_val;
    bit                        has_exp;
    logic [REGION_INDEX_W-1:0] exp_index;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             count_we = 1'b0;
  logic [RCOUNT_W-1:0]              count_val = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             kind = 1'b0;
  logic [SLOT_W-1:0]                slot = '0;
  logic [SHAPE_W-1:0]               shape = '0;
  logic signed [COORD_W-1:0]        x_low = '0;
  logic signed [COORD_W-1:0]        x_high = '0;
  logic signed [COORD_W-1:0]        y_low = '0;
  logic signed [COORD_W-1:0]        y_high = '0;
  logic [RADIUS_W-1:0]              radius = '0;
  logic signed [COORD_W-1:0]        center_x = '0;
  logic signed [COORD_W-1:0]        center_y = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [REGION_INDEX_W-1:0]        region_index;

  rpcc_entry_t                      region_table [MAX_REGIONS];
  logic [RCOUNT_W-1:0]              region_count_q = '0;
  logic [REGION_INDEX_W-1:0]        expected_index [$];
  stim_row_t                        directed_rows [$];
  int                               mismatches = 0;
  int                               results_done = 0;
  int                               send_idle_pct = 36;
  int                               recv_idle_pct = 73;
  int                               hold_left = 0;
  bit                               hold_done = 1'b0;

  region_priority_cell_classifier uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .region_count_we_i (count_we),
    .region_count_i    (count_val),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .kind_i            (kind),
    .slot_i            (slot),
    .shape_i           (shape),
    .x_low_i           (x_low),
    .x_high_i          (x_high),
    .y_low_i           (y_low),
    .y_high_i          (y_high),
    .radius_i          (radius),
    .center_x_i        (center_x),
    .center_y_i        (center_y),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .region_index_o    (region_index)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [COORD_W-1:0] fx(int units);
    return COORD_W'(units * 65536);
  endfunction

  // Last matching region among the first region_count entries, 0 if none.
  function automatic logic [REGION_INDEX_W-1:0] winning_region(region_req_t c);
    int                        n;
    int                        i;
    logic [REGION_INDEX_W-1:0] win;
    logic                      hit;
    longint                    dx;
    longint                    dy;
    longint                    r;
    rpcc_entry_t               e;
    win = '0;
    n = (int'(region_count_q) > MAX_REGIONS) ? MAX_REGIONS : int'(region_count_q);
    for (i = 0; i < n; i++) begin
      e = region_table[i];
      hit = 1'b0;
      case (e.shape)
        SHAPE_RECT: begin
          hit = ($signed(c.x_high) >= $signed(e.x_min)) && ($signed(c.x_low) < $signed(e.x_max))
             && ($signed(c.y_high) >= $signed(e.y_min)) && ($signed(c.y_low) < $signed(e.y_max));
        end
        SHAPE_CIRCLE: begin
          dx = longint'($signed(c.center_x)) - longint'($signed(e.x_min));
          dy = longint'($signed(c.center_y)) - longint'($signed(e.y_min));
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          r = longint'(e.radius);
          // bound check first so the squares cannot overflow
          if (dx <= r && dy <= r) hit = (dx * dx + dy * dy <= r * r);
        end
        SHAPE_POINT: begin
          hit = (c.x_low == e.x_min) && (c.y_low == e.y_min);
        end
        default: hit = 1'b0;
      endcase
      if (hit) win = REGION_INDEX_W'(i + 1);
    end
    return win;
  endfunction

  function automatic void store_region(region_req_t q);
    region_table[q.slot].shape  = q.shape;
    region_table[q.slot].x_min  = q.x_low;
    region_table[q.slot].x_max  = q.x_high;
    region_table[q.slot].y_min  = q.y_low;
    region_table[q.slot].y_max  = q.y_high;
    region_table[q.slot].radius = q.radius;
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: v = C_MIN;
      3: v = C_MAX;
      default: begin
        v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        // snap to whole units so bounds coincide often
        if ($urandom_range(0, 1) == 0) v[15:0] = '0;
      end
    endcase
    return v;
  endfunction

  function automatic logic [RADIUS_W-1:0] any_radius();
    logic [RADIUS_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = R_MAX;
      2: v = RADIUS_W'($urandom);
      default: v = RADIUS_W'($urandom_range(0, 32'h0006_0000));
    endcase
    return v;
  endfunction

  function automatic region_req_t random_load();
    region_req_t q;
    q.kind  = KIND_LOAD;
    q.slot  = SLOT_W'($urandom);
    q.shape = SHAPE_W'($urandom);
    q.x_low = any_coord();
    q.y_low = any_coord();
    if ($urandom_range(0, 9) < 7) begin
      q.x_high = q.x_low + COORD_W'($urandom_range(0, 32'h0004_0000));
      q.y_high = q.y_low + COORD_W'($urandom_range(0, 32'h0004_0000));
    end else begin
      q.x_high = any_coord();
      q.y_high = any_coord();
    end
    q.radius   = any_radius();
    q.center_x = $urandom;
    q.center_y = $urandom;
    return q;
  endfunction

  function automatic region_req_t random_cell();
    region_req_t q;
    rpcc_entry_t e;
    e = region_table[$urandom_range(0, MAX_REGIONS - 1)];
    q.kind   = KIND_CELL;
    q.slot   = SLOT_W'($urandom);
    q.shape  = SHAPE_W'($urandom);
    q.radius = RADIUS_W'($urandom);
    q.x_low  = any_coord();
    q.y_low  = any_coord();
    if ($urandom_range(0, 9) < 8) begin
      q.x_high = q.x_low + COORD_W'($urandom_range(0, 32'h0002_0000));
      q.y_high = q.y_low + COORD_W'($urandom_range(0, 32'h0002_0000));
    end else begin
      q.x_high = any_coord();
      q.y_high = any_coord();
    end
    q.center_x = any_coord();
    q.center_y = any_coord();
    // aim at a loaded region now and then so points and circles get hit
    case ($urandom_range(0, 3))
      0: begin
        q.x_low = e.x_min;
        q.y_low = e.y_min;
      end
      1: begin
        q.center_x = e.x_min + COORD_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        q.center_y = e.y_min + COORD_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic void add_load(logic [SLOT_W-1:0] s, logic [SHAPE_W-1:0] sh,
                                   logic signed [COORD_W-1:0] xl, logic signed [COORD_W-1:0] xh,
                                   logic signed [COORD_W-1:0] yl, logic signed [COORD_W-1:0] yh,
                                   logic [RADIUS_W-1:0] r);
    stim_row_t row;
    row.op           = ROW_ITEM;
    row.count_val    = '0;
    row.has_exp      = 1'b0;
    row.exp_index    = '0;
    row.req.kind     = KIND_LOAD;
    row.req.slot     = s;
    row.req.shape    = sh;
    row.req.x_low    = xl;
    row.req.x_high   = xh;
    row.req.y_low    = yl;
    row.req.y_high   = yh;
    row.req.radius   = r;
    row.req.center_x = $urandom;
    row.req.center_y = $urandom;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cell(logic signed [COORD_W-1:0] xl, logic signed [COORD_W-1:0] xh,
                                   logic signed [COORD_W-1:0] yl, logic signed [COORD_W-1:0] yh,
                                   logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                                   bit has_exp, logic [REGION_INDEX_W-1:0] want);
    stim_row_t row;
    row.op           = ROW_ITEM;
    row.count_val    = '0;
    row.has_exp      = has_exp;
    row.exp_index    = want;
    row.req.kind     = KIND_CELL;
    row.req.slot     = SLOT_W'($urandom);
    row.req.shape    = SHAPE_W'($urandom);
    row.req.radius   = RADIUS_W'($urandom);
    row.req.x_low    = xl;
    row.req.x_high   = xh;
    row.req.y_low    = yl;
    row.req.y_high   = yh;
    row.req.center_x = cx;
    row.req.center_y = cy;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_count(logic [RCOUNT_W-1:0] n);
    stim_row_t row;
    row.op        = ROW_COUNT;
    row.req       = '0;
    row.count_val = n;
    row.has_exp   = 1'b0;
    row.exp_index = '0;
    directed_rows.push_back(row);
  endfunction

  // Offer one transaction, hold it until accepted, then record a load in the model or predict a cell's result.
  task automatic send_request(region_req_t q, bit has_exp,
                              logic [REGION_INDEX_W-1:0] fixed_index);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= q.kind;
    slot     <= q.slot;
    shape    <= q.shape;
    x_low    <= q.x_low;
    x_high   <= q.x_high;
    y_low    <= q.y_low;
    y_high   <= q.y_high;
    radius   <= q.radius;
    center_x <= q.center_x;
    center_y <= q.center_y;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (q.kind == KIND_LOAD) store_region(q);
    else expected_index.push_back(has_exp ? fixed_index : winning_region(q));
  endtask

  // Drain the block, let a trailing load settle, then write the count.
  task automatic set_region_count(logic [RCOUNT_W-1:0] n);
    in_valid <= 1'b0;
    while (expected_index.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
    count_we  <= 1'b1;
    count_val <= n;
    @(posedge clk_i);
    count_we <= 1'b0;
    region_count_q = n;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_done >= HOLD_AT) begin
      // long back-pressure so the input side fills and stalls
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [REGION_INDEX_W-1:0] want;
    if (rst_ni && out_valid && out_ready) begin
      results_done <= results_done + 1;
      if (expected_index.size() == 0) begin
        if (mismatches < 10) $display("unexpected region_index %0d, no cell pending", region_index);
        mismatches++;
      end else begin
        want = expected_index.pop_front();
        if (region_index !== want) begin
          if (mismatches < 10)
            $display("region_index mismatch: expected %0d, actual %0d", want, region_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(24_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                  c;
    int                  k;
    logic [RCOUNT_W-1:0] n;
    stim_row_t           row;
    region_req_t         q;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // count is zero out of reset: everything is background
    add_cell(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, '0);
    add_cell(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, '0);
    add_load(4'd0, SHAPE_RECT, fx(-10), fx(10), fx(-10), fx(10), '0);
    add_load(4'd1, SHAPE_CIRCLE, fx(0), fx(0), fx(0), fx(0), RADIUS_W'(5 * 65536));
    add_load(4'd2, SHAPE_POINT, fx(3), fx(3), fx(4), fx(4), '0);
    add_load(4'd3, SHAPE_NONE, C_MIN, C_MAX, C_MIN, C_MAX, R_MAX);
    add_count(5'd4);
    add_cell(fx(3), fx(4), fx(4), fx(5), fx(3) + 32'sh8000, fx(4) + 32'sh8000, 1'b0, '0);
    // rectangle upper bound is open, lower bound closed
    add_cell(fx(10), fx(11), fx(-1), fx(1), fx(100), fx(100), 1'b0, '0);
    add_cell(fx(-11), fx(-10), fx(0), fx(1), fx(100), fx(100), 1'b0, '0);
    // center exactly on the circle, then one LSB outside
    add_cell(fx(100), fx(101), fx(100), fx(101), fx(3), fx(4), 1'b0, '0);
    add_cell(fx(100), fx(101), fx(100), fx(101), fx(3), fx(4) + 1, 1'b0, '0);
    add_cell(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, '0);
    add_load(4'd1, SHAPE_CIRCLE, C_MIN, fx(0), C_MIN, fx(0), R_MAX);
    add_cell(fx(100), fx(101), fx(100), fx(101), C_MIN, C_MIN, 1'b0, '0);
    add_cell(fx(100), fx(101), fx(100), fx(101), C_MAX, C_MAX, 1'b0, '0);
    add_cell(fx(100), fx(101), fx(100), fx(101), C_NEG_ONE, C_MIN, 1'b0, '0);
    add_load(4'd0, SHAPE_RECT, C_MIN, C_MAX, C_MIN, C_MAX, '0);
    add_count(5'd1);
    add_cell(C_MIN, C_MIN, C_MIN, C_MIN, fx(0), fx(0), 1'b0, '0);
    add_cell(C_MAX, C_MAX, C_MAX, C_MAX, fx(0), fx(0), 1'b0, '0);
    add_count(5'd0);
    add_cell(fx(3), fx(4), fx(4), fx(5), fx(3), fx(4), 1'b1, '0);

    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.op == ROW_COUNT) set_region_count(row.count_val);
      else send_request(row.req, row.has_exp, row.exp_index);
    end

    // fill the whole table before any count can reach an unloaded entry
    for (k = 0; k < MAX_REGIONS; k++) begin
      q = random_load();
      q.slot = SLOT_W'(k);
      send_request(q, 1'b0, '0);
    end

    for (c = 0; c < CHUNKS; c++) begin
      case (c)
        0: n = 5'd0;
        1: n = 5'd1;
        2: n = 5'd16;
        3: n = 5'd17;
        4: n = 5'd31;
        default: n = RCOUNT_W'($urandom_range(0, 31));
      endcase
      set_region_count(n);
      if (c == 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 36;
      end else if (c == 12) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (k = 0; k < CHUNK_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 7) q = random_cell();
        else q = random_load();
        send_request(q, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_index.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0 && expected_index.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
